[src/rk4op_pkg.sv]
// rk4op_pkg: types, codes and the micro-program of the rk4 orbit propagator
// shared by the controller, the datapath and the top level; no dependencies

package rk4op_pkg;

    localparam int ADDR_BITS  = 5;
    localparam int RAM_DEPTH  = 32;
    localparam int PC_BITS    = 7;
    localparam int CNT_BITS   = 3;
    localparam int STEP_BITS  = 31;
    localparam int FIELD_BITS = 32;

    localparam logic [STEP_BITS-1:0] STEP_RESET  = 31'd1677722;
    localparam logic [CNT_BITS-1:0]  RSQRT_ITERS = 3'd6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // scratch register file map
    localparam logic [ADDR_BITS-1:0] A_S   = 5'd0;
    localparam logic [ADDR_BITS-1:0] A_T   = 5'd4;
    localparam logic [ADDR_BITS-1:0] A_K   = 5'd8;
    localparam logic [ADDR_BITS-1:0] A_ACC = 5'd12;
    localparam logic [ADDR_BITS-1:0] A_HH  = 5'd16;
    localparam logic [ADDR_BITS-1:0] A_H6  = 5'd17;
    localparam logic [ADDR_BITS-1:0] A_H3  = 5'd18;
    localparam logic [ADDR_BITS-1:0] A_R2  = 5'd19;
    localparam logic [ADDR_BITS-1:0] A_Z   = 5'd20;
    localparam logic [ADDR_BITS-1:0] A_TT  = 5'd21;
    localparam logic [ADDR_BITS-1:0] A_IV  = 5'd22;
    localparam logic [ADDR_BITS-1:0] A_U   = 5'd23;

    localparam logic [PC_BITS-1:0] DERIV_PC = 7'd72;
    localparam logic [PC_BITS-1:0] LOOP_PC  = 7'd77;

    typedef enum logic [3:0] {
        UOP_MUL,
        UOP_ADD,
        UOP_ADDZ,
        UOP_SUB,
        UOP_MOV,
        UOP_SEED,
        UOP_CALL,
        UOP_RET,
        UOP_LDCNT,
        UOP_LOOP,
        UOP_END
    } uop_t;

    typedef enum logic [2:0] {
        SRC_RAM,
        SRC_HALF,
        SRC_SIXTH,
        SRC_THIRD,
        SRC_THREE,
        SRC_STEP
    } src_t;

    typedef struct packed {
        uop_t                 op;
        src_t                 a_sel;
        logic [ADDR_BITS-1:0] a_addr;
        src_t                 b_sel;
        logic [ADDR_BITS-1:0] b_addr;
        logic [ADDR_BITS-1:0] d_addr;
    } uinst_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_FETCH,
        ST_EXEC,
        ST_WB,
        ST_SEED,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   op;
        logic signed [FIELD_BITS-1:0] load_pos_x;
        logic signed [FIELD_BITS-1:0] load_pos_y;
        logic signed [FIELD_BITS-1:0] load_vel_x;
        logic signed [FIELD_BITS-1:0] load_vel_y;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] new_pos_x;
        logic signed [FIELD_BITS-1:0] new_pos_y;
        logic signed [FIELD_BITS-1:0] new_vel_x;
        logic signed [FIELD_BITS-1:0] new_vel_y;
        logic                   singular;
        logic                   saturated;
    } rsp_t;

    typedef struct packed {
        logic       capture;
        logic       load_wr;
        logic       clear;
        logic [1:0] load_idx;
        logic       ex;
        logic       wb;
        logic       seed;
        logic       finish;
        logic       sing;
        uinst_t     ui;
    } dp_cmd_t;

    typedef struct packed {
        logic zero;
        logic seed_found;
    } dp_sts_t;

    function automatic uinst_t mk(input uop_t op, input src_t as, input logic [ADDR_BITS-1:0] aa,
                                  input src_t bs, input logic [ADDR_BITS-1:0] ba,
                                  input logic [ADDR_BITS-1:0] d);
        uinst_t u;
        u.op     = op;
        u.a_sel  = as;
        u.a_addr = aa;
        u.b_sel  = bs;
        u.b_addr = ba;
        u.d_addr = d;
        return u;
    endfunction

    function automatic logic [ADDR_BITS-1:0] lane(input logic [ADDR_BITS-1:0] base,
                                                   input logic [1:0] i);
        return base + ADDR_BITS'(i);
    endfunction

    function automatic uinst_t ucode(input logic [PC_BITS-1:0] pc);
        uinst_t               u;
        logic [PC_BITS-1:0]   o;
        logic [1:0]           i;
        logic [1:0]           j;
        logic [1:0]           blk;
        u = mk(UOP_END, SRC_RAM, A_S, SRC_RAM, A_S, A_S);
        o = '0;
        i = '0;
        j = '0;
        blk = '0;
        if (pc == 7'd0) begin
            u = mk(UOP_MUL, SRC_HALF, A_S, SRC_STEP, A_S, A_HH);
        end else if (pc == 7'd1) begin
            u = mk(UOP_MUL, SRC_SIXTH, A_S, SRC_STEP, A_S, A_H6);
        end else if (pc == 7'd2) begin
            u = mk(UOP_MUL, SRC_THIRD, A_S, SRC_STEP, A_S, A_H3);
        end else if (pc < 7'd7) begin
            o = pc - 7'd3;
            i = o[1:0];
            u = mk(UOP_MOV, SRC_RAM, lane(A_S, i), SRC_RAM, A_S, lane(A_T, i));
        end else if (pc == 7'd7 || pc == 7'd24 || pc == 7'd41 || pc == 7'd58) begin
            u = mk(UOP_CALL, SRC_RAM, A_S, SRC_RAM, A_S, A_S);
        end else if (pc < 7'd58) begin
            if (pc < 7'd24) begin
                o = pc - 7'd8;
                blk = 2'd0;
            end else if (pc < 7'd41) begin
                o = pc - 7'd25;
                blk = 2'd1;
            end else begin
                o = pc - 7'd42;
                blk = 2'd2;
            end
            i = o[3:2];
            j = o[1:0];
            case (j)
                2'd0: u = mk(UOP_MUL, SRC_RAM, (blk == 2'd0) ? A_H6 : A_H3,
                             SRC_RAM, lane(A_K, i), A_U);
                2'd1: u = mk(UOP_ADD, SRC_RAM, (blk == 2'd0) ? lane(A_S, i) : lane(A_ACC, i),
                             SRC_RAM, A_U, lane(A_ACC, i));
                2'd2: u = mk(UOP_MUL, (blk == 2'd2) ? SRC_STEP : SRC_RAM, A_HH,
                             SRC_RAM, lane(A_K, i), A_U);
                default: u = mk(UOP_ADD, SRC_RAM, lane(A_S, i), SRC_RAM, A_U, lane(A_T, i));
            endcase
        end else if (pc < 7'd67) begin
            o = pc - 7'd59;
            i = o[2:1];
            if (o[0] == 1'b0) begin
                u = mk(UOP_MUL, SRC_RAM, A_H6, SRC_RAM, lane(A_K, i), A_U);
            end else begin
                u = mk(UOP_ADD, SRC_RAM, lane(A_ACC, i), SRC_RAM, A_U, lane(A_ACC, i));
            end
        end else if (pc < 7'd71) begin
            o = pc - 7'd67;
            i = o[1:0];
            u = mk(UOP_MOV, SRC_RAM, lane(A_ACC, i), SRC_RAM, A_S, lane(A_S, i));
        end else if (pc >= DERIV_PC) begin
            o = pc - DERIV_PC;
            case (o)
                7'd0:  u = mk(UOP_MUL, SRC_RAM, A_T, SRC_RAM, A_T, A_U);
                7'd1:  u = mk(UOP_MUL, SRC_RAM, lane(A_T, 2'd1), SRC_RAM, lane(A_T, 2'd1), A_TT);
                7'd2:  u = mk(UOP_ADDZ, SRC_RAM, A_U, SRC_RAM, A_TT, A_R2);
                7'd3:  u = mk(UOP_SEED, SRC_RAM, A_R2, SRC_RAM, A_R2, A_Z);
                7'd4:  u = mk(UOP_LDCNT, SRC_RAM, A_S, SRC_RAM, A_S, A_S);
                7'd5:  u = mk(UOP_MUL, SRC_RAM, A_Z, SRC_RAM, A_Z, A_TT);
                7'd6:  u = mk(UOP_MUL, SRC_RAM, A_R2, SRC_RAM, A_TT, A_TT);
                7'd7:  u = mk(UOP_SUB, SRC_THREE, A_S, SRC_RAM, A_TT, A_TT);
                7'd8:  u = mk(UOP_MUL, SRC_RAM, A_Z, SRC_RAM, A_TT, A_TT);
                7'd9:  u = mk(UOP_MUL, SRC_RAM, A_TT, SRC_HALF, A_S, A_Z);
                7'd10: u = mk(UOP_LOOP, SRC_RAM, A_S, SRC_RAM, A_S, A_S);
                7'd11: u = mk(UOP_MUL, SRC_RAM, A_Z, SRC_RAM, A_Z, A_IV);
                7'd12: u = mk(UOP_MUL, SRC_RAM, A_IV, SRC_RAM, A_Z, A_IV);
                7'd13: u = mk(UOP_MOV, SRC_RAM, lane(A_T, 2'd2), SRC_RAM, A_S, A_K);
                7'd14: u = mk(UOP_MOV, SRC_RAM, lane(A_T, 2'd3), SRC_RAM, A_S, lane(A_K, 2'd1));
                7'd15: u = mk(UOP_MUL, SRC_RAM, A_T, SRC_RAM, A_IV, lane(A_K, 2'd2));
                7'd16: u = mk(UOP_MUL, SRC_RAM, lane(A_T, 2'd1), SRC_RAM, A_IV, lane(A_K, 2'd3));
                7'd17: u = mk(UOP_RET, SRC_RAM, A_S, SRC_RAM, A_S, A_S);
                default: u = mk(UOP_END, SRC_RAM, A_S, SRC_RAM, A_S, A_S);
            endcase
        end
        return u;
    endfunction

endpackage

[src/rk4op_ram.sv]
// rk4op_ram: generic register-file memory, one write port, two registered read ports
// no dependencies

module rk4op_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[src/rk4op_ctrl.sv]
// rk4op_ctrl: sequencer that steps the micro-program and drives the datapath
// depends on rk4op_pkg

module rk4op_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               req_op,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rk4op_pkg::dp_cmd_t cmd,
    input  rk4op_pkg::dp_sts_t sts
);
    import rk4op_pkg::*;

    state_t               state_reg, state_next;
    logic [PC_BITS-1:0]   pc_reg, pc_next;
    logic [PC_BITS-1:0]   ret_reg, ret_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 sing_reg, sing_next;
    logic                 valid_reg, valid_next;
    uinst_t               ui;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pc_reg    <= '0;
            ret_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            sing_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            sing_reg  <= sing_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        ui         = ucode(pc_reg);
        state_next = state_reg;
        pc_next    = pc_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        sing_next  = sing_reg;
        valid_next = valid_reg && rsp_stall;
        req_stall  = 1'b1;
        cmd        = '0;
        cmd.ui     = ui;
        cmd.sing   = sing_reg;
        cmd.load_idx = idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                idx_next  = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    sing_next   = 1'b0;
                    idx_next    = '0;
                    pc_next     = '0;
                    state_next  = (req_op == OP_STEP) ? ST_FETCH : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                idx_next    = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FETCH:
            begin
                case (ui.op)
                    UOP_CALL:
                    begin
                        ret_next = pc_reg + 7'd1;
                        pc_next  = DERIV_PC;
                    end
                    UOP_RET:
                    begin
                        pc_next = ret_reg;
                    end
                    UOP_LDCNT:
                    begin
                        cnt_next = RSQRT_ITERS;
                        pc_next  = pc_reg + 7'd1;
                    end
                    UOP_LOOP:
                    begin
                        cnt_next = cnt_reg - 3'd1;
                        pc_next  = (cnt_reg != 3'd1) ? LOOP_PC : pc_reg + 7'd1;
                    end
                    UOP_END:
                    begin
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_EXEC;
                    end
                endcase
            end
            ST_EXEC:
            begin
                cmd.ex     = 1'b1;
                state_next = (ui.op == UOP_SEED) ? ST_SEED : ST_WB;
            end
            ST_WB:
            begin
                cmd.wb = 1'b1;
                if (ui.op == UOP_ADDZ && sts.zero)
                begin
                    sing_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    pc_next    = pc_reg + 7'd1;
                    state_next = ST_FETCH;
                end
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
                if (sts.seed_found)
                begin
                    pc_next    = pc_reg + 7'd1;
                    state_next = ST_FETCH;
                end
            end
            ST_DONE:
            begin
                if (!valid_reg || !rsp_stall)
                begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = valid_reg;

endmodule

[src/rk4op_dp.sv]
// rk4op_dp: datapath with scratch memory, shared multiplier and saturating alu
// depends on rk4op_pkg and rk4op_ram

module rk4op_dp #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rk4op_pkg::dp_cmd_t                  cmd,
    output rk4op_pkg::dp_sts_t                  sts,
    input  rk4op_pkg::req_t                     req_data,
    input  logic [rk4op_pkg::STEP_BITS-1:0]     step,
    output rk4op_pkg::rsp_t                     rsp_data
);
    import rk4op_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int IW = $clog2(W);
    localparam logic [63:0] MAXV64 = (64'd1 << (W - 1)) - 64'd1;
    localparam logic [63:0] MINV64 = ~MAXV64;
    localparam logic [W-1:0] MAXV = MAXV64[W-1:0];
    localparam logic [W-1:0] MINV = MINV64[W-1:0];
    localparam logic [63:0] HALF64  = 64'd1 << (F - 1);
    localparam logic [63:0] SIXTH64 = ((64'd1 << F) + 64'd3) / 64'd6;
    localparam logic [63:0] THIRD64 = ((64'd1 << F) + 64'd1) / 64'd3;
    localparam logic [63:0] THREE64 = 64'd3 << F;
    localparam logic [W-1:0] C_HALF  = (HALF64 > MAXV64) ? MAXV : HALF64[W-1:0];
    localparam logic [W-1:0] C_SIXTH = (SIXTH64 > MAXV64) ? MAXV : SIXTH64[W-1:0];
    localparam logic [W-1:0] C_THIRD = (THIRD64 > MAXV64) ? MAXV : THIRD64[W-1:0];
    localparam logic [W-1:0] C_THREE = (THREE64 > MAXV64) ? MAXV : THREE64[W-1:0];

    req_t                 in_reg;
    logic [W-1:0]         a_reg;
    logic [W-1:0]         b_reg;
    logic [2*W-1:0]       prod_reg;
    logic                 neg_reg;
    logic [IW-1:0]        idx_reg;
    logic                 sat_reg;
    logic [W-1:0]         st_reg [4];
    rsp_t                 res_reg;

    logic [W-1:0]         rdata_a, rdata_b;
    logic [W-1:0]         opa, opb, mag_a, mag_b;
    logic [63:0]          step64;
    logic                 h_over;
    logic [W-1:0]         h_val;
    logic                 ex_sat;

    logic [2*W-1:0]       q, lim, qm;
    logic                 mul_sat;
    logic [W-1:0]         mul_res;
    logic [W:0]           sum, diff;
    logic [W-1:0]         sum_c, diff_c, alu_res;
    logic                 alu_sat;

    int                   m, s, c, sh;
    logic [W-1:0]         seed_val;
    logic                 seed_sat;
    logic                 found;

    logic signed [FIELD_BITS-1:0] lf;
    logic signed [63:0]   lw;
    logic [W-1:0]         lv;
    logic                 lv_sat;

    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [W-1:0]         wdata;
    logic                 wsat;

    logic signed [63:0]   ov [4];
    logic [FIELD_BITS-1:0] o32 [4];
    logic [3:0]           oclamp;

    rk4op_ram #(
        .WIDTH (W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (cmd.ui.a_addr),
        .raddr_b (cmd.ui.b_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // operand selection
    always_comb
    begin
        step64 = 64'(step);
        h_over = step64 > MAXV64;
        h_val  = h_over ? MAXV : step64[W-1:0];
        case (cmd.ui.a_sel)
            SRC_HALF:  opa = C_HALF;
            SRC_SIXTH: opa = C_SIXTH;
            SRC_THIRD: opa = C_THIRD;
            SRC_THREE: opa = C_THREE;
            SRC_STEP:  opa = h_val;
            default:   opa = rdata_a;
        endcase
        case (cmd.ui.b_sel)
            SRC_HALF:  opb = C_HALF;
            SRC_SIXTH: opb = C_SIXTH;
            SRC_THIRD: opb = C_THIRD;
            SRC_THREE: opb = C_THREE;
            SRC_STEP:  opb = h_val;
            default:   opb = rdata_b;
        endcase
        mag_a  = opa[W-1] ? (-opa) : opa;
        mag_b  = opb[W-1] ? (-opb) : opb;
        ex_sat = h_over && (cmd.ui.a_sel == SRC_STEP || cmd.ui.b_sel == SRC_STEP);
    end

    // product scaling and saturating add and subtract
    always_comb
    begin
        q       = prod_reg >> F;
        lim     = neg_reg ? ((2 * W)'(1) << (W - 1)) : (2 * W)'(MAXV);
        mul_sat = q > lim;
        qm      = mul_sat ? lim : q;
        mul_res = neg_reg ? (-qm[W-1:0]) : qm[W-1:0];
        sum     = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
        diff    = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
        sum_c   = (sum[W] != sum[W-1]) ? (sum[W] ? MINV : MAXV) : sum[W-1:0];
        diff_c  = (diff[W] != diff[W-1]) ? (diff[W] ? MINV : MAXV) : diff[W-1:0];
        case (cmd.ui.op)
            UOP_MUL:
            begin
                alu_res = mul_res;
                alu_sat = mul_sat;
            end
            UOP_ADD, UOP_ADDZ:
            begin
                alu_res = sum_c;
                alu_sat = sum[W] != sum[W-1];
            end
            UOP_SUB:
            begin
                alu_res = diff_c;
                alu_sat = diff[W] != diff[W-1];
            end
            default:
            begin
                alu_res = a_reg;
                alu_sat = 1'b0;
            end
        endcase
    end

    // reciprocal square root seed from the leading one
    always_comb
    begin
        found = a_reg[idx_reg];
        m     = int'(idx_reg);
        s     = m - F;
        c     = (s + 1) >>> 1;
        sh    = F - c;
        seed_sat = 1'b0;
        if (sh >= W - 1)
        begin
            seed_val = MAXV;
            seed_sat = 1'b1;
        end
        else if (sh < 0)
        begin
            seed_val = '0;
        end
        else
        begin
            seed_val = W'(1) << sh;
        end
    end

    // load value clamp
    always_comb
    begin
        case (cmd.load_idx)
            2'd0:    lf = in_reg.load_pos_x;
            2'd1:    lf = in_reg.load_pos_y;
            2'd2:    lf = in_reg.load_vel_x;
            default: lf = in_reg.load_vel_y;
        endcase
        lw     = 64'(lf);
        lv_sat = 1'b1;
        if (lw > $signed(MAXV64))
        begin
            lv = MAXV;
        end
        else if (lw < $signed(MINV64))
        begin
            lv = MINV;
        end
        else
        begin
            lv     = lw[W-1:0];
            lv_sat = 1'b0;
        end
    end

    // write port
    always_comb
    begin
        we    = 1'b0;
        waddr = cmd.ui.d_addr;
        wdata = alu_res;
        wsat  = 1'b0;
        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = lane(A_S, cmd.load_idx);
            wdata = '0;
        end
        else if (cmd.load_wr)
        begin
            we    = 1'b1;
            waddr = lane(A_S, cmd.load_idx);
            wdata = lv;
            wsat  = lv_sat;
        end
        else if (cmd.seed)
        begin
            we    = found;
            wdata = seed_val;
            wsat  = found && seed_sat;
        end
        else if (cmd.wb)
        begin
            we    = 1'b1;
            wsat  = alu_sat;
        end
    end

    // result assembly with 32-bit output clamp
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ov[i]     = 64'($signed(st_reg[i]));
            oclamp[i] = 1'b1;
            if (ov[i] > 64'sh7FFFFFFF)
            begin
                o32[i] = 32'h7FFFFFFF;
            end
            else if (ov[i] < -64'sh80000000)
            begin
                o32[i] = 32'h80000000;
            end
            else
            begin
                o32[i]    = ov[i][31:0];
                oclamp[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                sat_reg <= 1'b0;
            end
            else if ((cmd.ex && ex_sat) || wsat)
            begin
                sat_reg <= 1'b1;
            end
            if (we && waddr[ADDR_BITS-1:2] == '0)
            begin
                st_reg[waddr[1:0]] <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= req_data;
        end
        if (cmd.ex)
        begin
            a_reg    <= opa;
            b_reg    <= opb;
            prod_reg <= (2 * W)'(mag_a) * (2 * W)'(mag_b);
            neg_reg  <= opa[W-1] ^ opb[W-1];
            idx_reg  <= IW'(W - 1);
        end
        else if (cmd.seed && !found)
        begin
            idx_reg <= idx_reg - IW'(1);
        end
        if (cmd.finish)
        begin
            res_reg.new_pos_x <= o32[0];
            res_reg.new_pos_y <= o32[1];
            res_reg.new_vel_x <= o32[2];
            res_reg.new_vel_y <= o32[3];
            res_reg.singular  <= cmd.sing;
            res_reg.saturated <= (sat_reg && !cmd.sing) || (|oclamp);
        end
    end

    assign sts.zero       = (alu_res == '0);
    assign sts.seed_found = found;
    assign rsp_data       = res_reg;

endmodule

[src/rk4_orbit_propagator.sv]
// rk4_orbit_propagator: top level, step-size register, controller and datapath
// depends on rk4op_pkg, rk4op_ctrl, rk4op_dp

// Planar two-body propagator in signed fixed point. A load item replaces position and
// velocity; a step item runs one fourth-order Runge-Kutta step as a micro-program on one
// shared multiplier and saturating adder, each arithmetic micro-operation passing through
// fetch, execute and write-back states and each control one through fetch alone, plus a
// leading-one scan for each of the four reciprocal square root seeds. A zero radius ends
// the step early. A new item is taken while the last result still waits in the output
// register. After reset a clearing pass zeroes the state before the first item is taken.
// step_size may be written only while idle.
module rk4_orbit_propagator #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  rk4op_pkg::req_t                  req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output rk4op_pkg::rsp_t                  rsp_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rk4op_pkg::STEP_BITS-1:0]  cfg_data
);
    import rk4op_pkg::*;

    logic [STEP_BITS-1:0] step_reg;
    dp_cmd_t              cmd;
    dp_sts_t              sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            step_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    rk4op_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_op    (req_data.op),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rk4op_dp #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_data (req_data),
        .step     (step_reg),
        .rsp_data (rsp_data)
    );

endmodule
